@@ rtl/tpr_pkg.sv @@
// Shared types and constants of the tachometer period-to-speed unit.
package tpr_pkg;

  localparam int RATE_WIDTH     = 32;
  localparam int RELOAD_WIDTH   = 3;
  localparam int TIMEOUT_WIDTH  = 4;
  localparam int SPEED_WIDTH    = 16;
  localparam int STAMP_IN_WIDTH = 16;
  localparam int CHANNEL_WIDTH  = 2;
  localparam int OUT_FIELDS     = 4;

  localparam logic [RATE_WIDTH-1:0]           RATE_RESET    = 32'd60000000;
  localparam logic [RELOAD_WIDTH-1:0]         RELOAD_RESET  = 3'd2;
  localparam logic signed [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 4'sd2;
  localparam logic [SPEED_WIDTH-1:0]          SPEED_MAX     = 16'hFFFF;

  // Configuration register indexes
  localparam logic REG_RATE   = 1'b0;
  localparam logic REG_RELOAD = 1'b1;

  // Item kinds
  localparam logic ACT_CAPTURE = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_DELIVER
  } tpr_state_t;

  typedef struct packed {
    logic take_item;
    logic start_div;
    logic store_speed;
    logic load_out;
  } tpr_cmd_t;

  typedef struct packed {
    logic capture_ok;
    logic div_done;
  } tpr_status_t;

endpackage

@@ rtl/tachometer_period_to_rpm_unit.sv @@
// Top level of the four-channel tachometer period-to-speed unit.
//
// Each input transaction is either a capture (action 0: a channel, a timer
// stamp and an overrun flag) or a timer tick (action 1), and each one yields
// exactly one output transaction carrying the speeds of all four channels
// after the update. A capture turns the time since the channel's previous
// stamp into a period, alternates it between two slots, and divides
// rate_numerator by the sum of both slots in a shared restoring divider that
// produces one quotient bit per clock; quotients above 65535, or a zero slot
// sum, read as 65535. After acceptance a capture passes through the start,
// divide and deliver states before the next acceptance; a tick, or a
// capture on a nonexistent channel, goes to deliver. The result sits in an
// output register, so the next transaction is accepted while the previous
// result still waits under out_stall. Ticks count down each channel's
// timeout (loaded from timeout_reload on a capture); once it drops below
// zero that channel reads speed zero until its next capture. Write the
// configuration registers (index 0 rate_numerator, index 1 timeout_reload)
// only while the unit is idle.
module tachometer_period_to_rpm_unit #(
  parameter int NUM_CHANNELS = 4,
  parameter int STAMP_WIDTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic                                 wr_index,
  input  logic [tpr_pkg::RATE_WIDTH-1:0]       wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [tpr_pkg::CHANNEL_WIDTH-1:0]    channel,
  input  logic [tpr_pkg::STAMP_IN_WIDTH-1:0]   capture_value,
  input  logic                                 overrun,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tpr_pkg::SPEED_WIDTH-1:0]      speed_ch0,
  output logic [tpr_pkg::SPEED_WIDTH-1:0]      speed_ch1,
  output logic [tpr_pkg::SPEED_WIDTH-1:0]      speed_ch2,
  output logic [tpr_pkg::SPEED_WIDTH-1:0]      speed_ch3
);

  tpr_pkg::tpr_cmd_t    cmd;
  tpr_pkg::tpr_status_t status;
  logic [tpr_pkg::SPEED_WIDTH-1:0] speed_out [tpr_pkg::OUT_FIELDS];

  // Sequencing: accept, start divider, wait, store speed, hand off result.
  tpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Per-channel state, divider and the result register.
  tpr_dp #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .action        (action),
    .channel       (channel),
    .capture_value (capture_value),
    .overrun       (overrun),
    .speed_out     (speed_out)
  );

  assign speed_ch0 = speed_out[0];
  assign speed_ch1 = speed_out[1];
  assign speed_ch2 = speed_out[2];
  assign speed_ch3 = speed_out[3];

  // Never overwrite a result that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // In the cycle after an accepted transaction the unit is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("transaction accepted back to back");

  // The divider only starts while no new transaction can enter.
  a_div_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |-> in_stall)
    else $error("divider started while idle");

  // A divider result arrives only while the unit is busy with a capture.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (in_stall && !cmd.load_out))
    else $error("divider finished outside a capture");

endmodule

@@ rtl/tpr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module tpr_div #(
  parameter int DIVISOR_WIDTH = 17
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [tpr_pkg::RATE_WIDTH-1:0]       dividend,
  input  logic [DIVISOR_WIDTH-1:0]             divisor,
  output logic                                 done,
  output logic [tpr_pkg::RATE_WIDTH-1:0]       quotient
);

  localparam int CNT_WIDTH = $clog2(tpr_pkg::RATE_WIDTH);
  localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(tpr_pkg::RATE_WIDTH - 1);

  logic                     busy;
  logic [CNT_WIDTH-1:0]     count;
  logic [DIVISOR_WIDTH-1:0] dsor;
  logic [DIVISOR_WIDTH-1:0] rem;
  logic [DIVISOR_WIDTH-1:0] rem_next;
  logic [DIVISOR_WIDTH:0]   trial;
  logic                     fits;

  // A zero divisor always fits, so the quotient comes out all ones.
  always_comb begin
    trial    = {rem, quotient[tpr_pkg::RATE_WIDTH-1]};
    fits     = (trial >= {1'b0, dsor});
    rem_next = fits ? DIVISOR_WIDTH'(trial - {1'b0, dsor}) : DIVISOR_WIDTH'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsor     <= divisor;
    end else if (busy) begin
      quotient <= {quotient[tpr_pkg::RATE_WIDTH-2:0], fits};
      rem      <= rem_next;
    end
  end

endmodule

@@ rtl/tpr_dp.sv @@
// Datapath: per-channel stamps, period slots, timeouts, speeds and result register.
module tpr_dp #(
  parameter int NUM_CHANNELS = 4,
  parameter int STAMP_WIDTH  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  tpr_pkg::tpr_cmd_t                        cmd,
  output tpr_pkg::tpr_status_t                     status,
  input  logic                                     wr_en,
  input  logic                                     wr_index,
  input  logic [tpr_pkg::RATE_WIDTH-1:0]           wr_data,
  input  logic                                     action,
  input  logic [tpr_pkg::CHANNEL_WIDTH-1:0]        channel,
  input  logic [tpr_pkg::STAMP_IN_WIDTH-1:0]       capture_value,
  input  logic                                     overrun,
  output logic [tpr_pkg::SPEED_WIDTH-1:0]          speed_out [tpr_pkg::OUT_FIELDS]
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DW = STAMP_WIDTH + 1;

  logic [tpr_pkg::RATE_WIDTH-1:0]             rate_numerator;
  logic [tpr_pkg::RELOAD_WIDTH-1:0]           timeout_reload;
  logic [STAMP_WIDTH-1:0]                     last_stamp   [NUM_CHANNELS];
  logic [STAMP_WIDTH-1:0]                     slot0        [NUM_CHANNELS];
  logic [STAMP_WIDTH-1:0]                     slot1        [NUM_CHANNELS];
  logic                                       slot_toggle  [NUM_CHANNELS];
  logic signed [tpr_pkg::TIMEOUT_WIDTH-1:0]   timeout_left [NUM_CHANNELS];
  logic signed [tpr_pkg::TIMEOUT_WIDTH-1:0]   timeout_next [NUM_CHANNELS];
  logic [tpr_pkg::SPEED_WIDTH-1:0]            speed_value  [NUM_CHANNELS];
  logic [tpr_pkg::SPEED_WIDTH-1:0]            snap         [tpr_pkg::OUT_FIELDS];
  logic [CW-1:0]                              cur_ch;

  logic [CW-1:0]                  ch_idx;
  logic [STAMP_WIDTH-1:0]         stamp;
  logic [STAMP_WIDTH-1:0]         old_stamp;
  logic [STAMP_WIDTH-1:0]         period;
  logic [DW-1:0]                  divisor;
  logic                           div_done;
  logic [tpr_pkg::RATE_WIDTH-1:0] quotient;
  logic [tpr_pkg::SPEED_WIDTH-1:0] speed_sat;

  // Capture decode: an overrun restarts from the new stamp, giving a full-scale period.
  always_comb begin
    ch_idx    = CW'(channel);
    stamp     = STAMP_WIDTH'(capture_value);
    old_stamp = overrun ? stamp : last_stamp[ch_idx];
    period    = (stamp > old_stamp) ? (stamp - old_stamp)
                                    : (stamp - old_stamp - STAMP_WIDTH'(1));
    status.capture_ok = (action == tpr_pkg::ACT_CAPTURE) && (int'(channel) < NUM_CHANNELS);
    status.div_done   = div_done;
    divisor   = {1'b0, slot0[cur_ch]} + {1'b0, slot1[cur_ch]};
    speed_sat = (|quotient[tpr_pkg::RATE_WIDTH-1:tpr_pkg::SPEED_WIDTH]) ? tpr_pkg::SPEED_MAX
                : quotient[tpr_pkg::SPEED_WIDTH-1:0];
  end

  // Tick: count down, hold at minus one.
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      timeout_next[i] = timeout_left[i][tpr_pkg::TIMEOUT_WIDTH-1] ? timeout_left[i]
                        : timeout_left[i] - 4'sd1;
    end
  end

  for (genvar j = 0; j < tpr_pkg::OUT_FIELDS; j++) begin : g_snap
    if (j < NUM_CHANNELS) begin : g_on
      assign snap[j] = speed_value[j];
    end else begin : g_off
      assign snap[j] = '0;
    end
  end

  tpr_div #(
    .DIVISOR_WIDTH(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (rate_numerator),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_numerator <= tpr_pkg::RATE_RESET;
      timeout_reload <= tpr_pkg::RELOAD_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_stamp[i]   <= '0;
        slot0[i]        <= '0;
        slot1[i]        <= '0;
        slot_toggle[i]  <= 1'b0;
        timeout_left[i] <= tpr_pkg::TIMEOUT_RESET;
        speed_value[i]  <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          tpr_pkg::REG_RATE:   rate_numerator <= wr_data;
          tpr_pkg::REG_RELOAD: timeout_reload <= wr_data[tpr_pkg::RELOAD_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cmd.take_item) begin
        if (status.capture_ok) begin
          if (slot_toggle[ch_idx]) begin
            slot1[ch_idx] <= period;
          end else begin
            slot0[ch_idx] <= period;
          end
          slot_toggle[ch_idx]  <= ~slot_toggle[ch_idx];
          last_stamp[ch_idx]   <= stamp;
          timeout_left[ch_idx] <= $signed({1'b0, timeout_reload});
        end else if (action == tpr_pkg::ACT_TICK) begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            timeout_left[i] <= timeout_next[i];
            if (timeout_next[i] < 0) begin
              speed_value[i] <= '0;
            end
          end
        end
      end
      if (cmd.store_speed) begin
        speed_value[cur_ch] <= speed_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      cur_ch <= ch_idx;
    end
    if (cmd.load_out) begin
      speed_out <= snap;
    end
  end

endmodule

@@ rtl/tpr_ctrl.sv @@
// Controller: sequences accept, divide, store and result hand-off.
module tpr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  tpr_pkg::tpr_status_t  status,
  output tpr_pkg::tpr_cmd_t     cmd
);

  tpr_pkg::tpr_state_t state;
  tpr_pkg::tpr_state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      tpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.capture_ok ? tpr_pkg::ST_START : tpr_pkg::ST_DELIVER;
        end
      end
      tpr_pkg::ST_START:  state_next = tpr_pkg::ST_DIVIDE;
      tpr_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = tpr_pkg::ST_DELIVER;
        end
      end
      tpr_pkg::ST_DELIVER: begin
        if (!out_valid || !out_stall) begin
          state_next = tpr_pkg::ST_IDLE;
        end
      end
      default: state_next = tpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      tpr_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_item = in_valid;
      end
      tpr_pkg::ST_START:   cmd.start_div   = 1'b1;
      tpr_pkg::ST_DIVIDE:  cmd.store_speed = status.div_done;
      tpr_pkg::ST_DELIVER: cmd.load_out    = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
